[hdl/sfpg_pkg.sv]
package sfpg_pkg;

	// Default width of the millisecond timebase and of the deadline.
	localparam int TIME_BITS_DEF = 32;

	// Configuration port geometry.
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 16;

	// Command carried by each request.
	typedef enum logic [1:0] {
		KIND_TICK      = 2'd0,
		KIND_START     = 2'd1,
		KIND_START_LAG = 2'd2,
		KIND_STOP      = 2'd3
	} kind_t;

	// Configuration register indexes.
	localparam logic [CFG_IDX_BITS-1:0] CFG_STROBE_MODE   = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_FLASH_ON_MS   = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_FLASH_OFF_MS  = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_STEADY_ON_MS  = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_STEADY_OFF_MS = 3'd4;

	// Strobe modes.
	localparam logic [1:0] MODE_TRIPLE  = 2'd0;
	localparam logic [1:0] MODE_TWO_ONE = 2'd1;
	localparam logic [1:0] MODE_STEADY  = 2'd2;

	// Register values after reset.
	localparam logic [1:0]  RST_STROBE_MODE   = MODE_TRIPLE;
	localparam logic [10:0] RST_FLASH_ON_MS   = 11'd100;
	localparam logic [15:0] RST_FLASH_OFF_MS  = 16'd900;
	localparam logic [15:0] RST_STEADY_ON_MS  = 16'd100;
	localparam logic [15:0] RST_STEADY_OFF_MS = 16'd1900;

	// Period that the long gap fills up to, and pulses in one pattern cycle.
	localparam logic [10:0] LONG_PERIOD_MS = 11'd2000;
	localparam logic [2:0]  PULSE_COUNT    = 3'd5;

	typedef struct packed {
		logic [1:0]  strobe_mode;
		logic [10:0] flash_on_ms;
		logic [15:0] flash_off_ms;
		logic [15:0] steady_on_ms;
		logic [15:0] steady_off_ms;
	} cfg_t;

	typedef struct packed {
		logic led_on;
		logic is_running;
	} result_t;

endpackage

[hdl/sfpg_cfg_regs.sv]
module sfpg_cfg_regs
	import sfpg_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  logic [CFG_IDX_BITS-1:0]  wr_index,
	input  logic [CFG_DATA_BITS-1:0] wr_data,
	output cfg_t                     cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.strobe_mode   <= RST_STROBE_MODE;
			cfg_q.flash_on_ms   <= RST_FLASH_ON_MS;
			cfg_q.flash_off_ms  <= RST_FLASH_OFF_MS;
			cfg_q.steady_on_ms  <= RST_STEADY_ON_MS;
			cfg_q.steady_off_ms <= RST_STEADY_OFF_MS;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_STROBE_MODE:   cfg_q.strobe_mode   <= wr_data[1:0];
				CFG_FLASH_ON_MS:   cfg_q.flash_on_ms   <= wr_data[10:0];
				CFG_FLASH_OFF_MS:  cfg_q.flash_off_ms  <= wr_data;
				CFG_STEADY_ON_MS:  cfg_q.steady_on_ms  <= wr_data;
				CFG_STEADY_OFF_MS: cfg_q.steady_off_ms <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[hdl/sfpg_step.sv]
module sfpg_step
	import sfpg_pkg::*;
#(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  kind_t                kind,
	input  logic [TIME_BITS-1:0] time_now,
	input  logic [15:0]          lag_delay,
	input  cfg_t                 cfg,
	output result_t              result
);

	logic                 running_q,  running_d;
	logic                 lit_half_q, lit_half_d;
	logic [2:0]           pulse_q,    pulse_d;
	logic [TIME_BITS-1:0] deadline_q, deadline_d;
	logic                 led_q,      led_d;

	logic                 due;
	logic [10:0]          long_gap;
	logic [TIME_BITS-1:0] step_amt;
	logic [2:0]           pulse_inc;

	// Pulses that are lit in the flash modes.
	function automatic logic pattern_lights(logic [1:0] mode, logic [2:0] p);
		if (mode == MODE_TRIPLE)
			return p < 3'd3;
		return (p < 3'd2) || (p == 3'd3);
	endfunction

	assign due       = running_q && (deadline_q <= time_now);
	assign long_gap  = (cfg.flash_on_ms > LONG_PERIOD_MS) ? 11'd0
	                   : LONG_PERIOD_MS - cfg.flash_on_ms;
	assign pulse_inc = pulse_q + 3'd1;

	always_comb begin
		running_d  = running_q;
		lit_half_d = lit_half_q;
		pulse_d    = pulse_q;
		deadline_d = deadline_q;
		led_d      = led_q;
		step_amt   = '0;
		unique case (kind)
			KIND_START: begin
				deadline_d = time_now + TIME_BITS'(cfg.flash_on_ms);
				running_d  = 1'b1;
				lit_half_d = 1'b1;
				pulse_d    = '0;
				led_d      = 1'b1;
			end
			KIND_START_LAG: begin
				deadline_d = time_now + TIME_BITS'(cfg.flash_on_ms) + TIME_BITS'(lag_delay);
				running_d  = 1'b1;
				lit_half_d = 1'b0;
				pulse_d    = '0;
				led_d      = 1'b0;
			end
			KIND_STOP: begin
				running_d = 1'b0;
				if (running_q)
					led_d = 1'b0;
			end
			default: begin
				if (due) begin
					lit_half_d = !lit_half_q;
					if (cfg.strobe_mode >= MODE_STEADY) begin
						led_d    = !lit_half_q;
						step_amt = !lit_half_q ? TIME_BITS'(cfg.steady_on_ms)
						           : TIME_BITS'(cfg.steady_off_ms);
					end else if (lit_half_q) begin
						// Lit half ends: go dark and move to the next pulse.
						led_d = 1'b0;
						if (cfg.strobe_mode == MODE_TWO_ONE &&
						    !pattern_lights(MODE_TWO_ONE, pulse_q))
							step_amt = TIME_BITS'(long_gap);
						else
							step_amt = TIME_BITS'(cfg.flash_off_ms);
						pulse_d = (pulse_inc >= PULSE_COUNT) ? 3'd0 : pulse_inc;
					end else begin
						led_d    = pattern_lights(cfg.strobe_mode, pulse_q);
						step_amt = TIME_BITS'(cfg.flash_on_ms);
					end
					deadline_d = deadline_q + step_amt;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q  <= 1'b0;
			lit_half_q <= 1'b0;
			pulse_q    <= '0;
			deadline_q <= '0;
			led_q      <= 1'b0;
		end else if (fire) begin
			running_q  <= running_d;
			lit_half_q <= lit_half_d;
			pulse_q    <= pulse_d;
			deadline_q <= deadline_d;
			led_q      <= led_d;
		end
	end

	assign result.led_on     = led_d;
	assign result.is_running = running_d;

endmodule

[hdl/strobe_flash_pattern_generator.sv]
// Strobe flash pattern generator. Each request carries a command (tick, start,
// lagged start or stop) together with the current millisecond time and a lag;
// every request yields exactly one result holding the LED state and the running
// flag after that command. A request is registered on entry in the input
// register, then evaluated combinationally against the pattern state, and the
// result lands in the output register, so the block takes one request per clock
// while in_stall is low and presents each result from that output register.
// The output register and the input register form a two-deep pipe: a new request
// is taken while an earlier result still waits, and input stall rises only when
// both stages are full and the output is stalled. Configuration writes are always
// accepted (cfg_ready is high) and should be made while no request is in flight.
module strobe_flash_pattern_generator
	import sfpg_pkg::*;
#(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,

	// Request channel.
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               kind,
	input  logic [TIME_BITS-1:0]     time_now,
	input  logic [15:0]              lag_delay,

	// Result channel.
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     led_on,
	output logic                     is_running,

	// Configuration write channel.
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);

	cfg_t    cfg;
	result_t step_res;
	result_t res_q;
	logic    out_valid_q;

	// Input register stage.
	logic                 valid_s1;
	logic [1:0]           kind_s1;
	logic [TIME_BITS-1:0] time_s1;
	logic [15:0]          lag_s1;

	// The registered request is evaluated when the output register can take
	// its result, either because it is empty or because it is handed off now.
	logic advance;

	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign cfg_ready = 1'b1;

	sfpg_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	sfpg_step #(
		.TIME_BITS (TIME_BITS)
	) u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (advance),
		.kind      (kind_t'(kind_s1)),
		.time_now  (time_s1),
		.lag_delay (lag_s1),
		.cfg       (cfg),
		.result    (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// Request payload holds while the stage is stalled.
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			kind_s1 <= kind;
			time_s1 <= time_now;
			lag_s1  <= lag_delay;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= step_res;
	end

	assign out_valid  = out_valid_q;
	assign led_on     = res_q.led_on;
	assign is_running = res_q.is_running;

endmodule

[sim/strobe_flash_pattern_generator_tb.sv]
module strobe_flash_pattern_generator_tb;
	import sfpg_pkg::*;

	// The block runs with the default 32-bit timebase.
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int IDLE_PERCENT   = 23;
	localparam int PHASE_REQUESTS = 105;

	// Mode three has no name in the package. The block treats it as the steady blink.
	localparam logic [1:0] MODE_STEADY_ALT = 2'd3;

	// This index is not a register. A write to it must leave every setting unchanged.
	localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_IDX = 3'd7;

	// One row of the directed script. When "typed" is set, "want" holds the result
	// written out by hand, as {led_on, is_running}. Otherwise the predictor supplies it.
	typedef struct packed {
		kind_t       cmd;
		logic [31:0] now;
		logic [15:0] lag;
		logic        typed;
		result_t     want;
	} script_row_t;

	// The script starts from the reset settings: triple flash, 100 ms lit, 900 ms dark.
	// It checks ticks and stops while stopped, and it walks one whole five-pulse cycle,
	// with each deadline hit exactly. It also sends ticks one millisecond early, a lagged
	// start that wraps the deadline past the top of the timebase, a restart while running,
	// and the extreme values of time and lag.
	localparam script_row_t DIRECTED [23] = '{
		'{KIND_TICK,      32'd0,          16'd0,      1'b1, 2'b00},
		'{KIND_STOP,      32'd0,          16'd0,      1'b1, 2'b00},
		'{KIND_START,     32'd0,          16'hFFFF,   1'b1, 2'b11},
		'{KIND_TICK,      32'd99,         16'd0,      1'b0, 2'b00},
		'{KIND_TICK,      32'd100,        16'd0,      1'b0, 2'b00},
		'{KIND_TICK,      32'd1000,       16'd0,      1'b0, 2'b00},
		'{KIND_TICK,      32'd1100,       16'd0,      1'b0, 2'b00},
		'{KIND_TICK,      32'd2000,       16'd0,      1'b0, 2'b00},
		'{KIND_TICK,      32'd2100,       16'd0,      1'b0, 2'b00},
		'{KIND_TICK,      32'd3000,       16'd0,      1'b0, 2'b00},
		'{KIND_TICK,      32'd3100,       16'd0,      1'b0, 2'b00},
		'{KIND_TICK,      32'd4000,       16'd0,      1'b0, 2'b00},
		'{KIND_TICK,      32'd4100,       16'd0,      1'b0, 2'b00},
		'{KIND_TICK,      32'hFFFF_FFFF,  16'd0,      1'b0, 2'b00},
		'{KIND_STOP,      32'hFFFF_FFFF,  16'hFFFF,   1'b1, 2'b00},
		'{KIND_TICK,      32'hFFFF_FFFF,  16'hFFFF,   1'b1, 2'b00},
		'{KIND_START_LAG, 32'hFFFF_FFFF,  16'hFFFF,   1'b1, 2'b01},
		'{KIND_TICK,      32'd65633,      16'd0,      1'b0, 2'b00},
		'{KIND_TICK,      32'd65634,      16'd0,      1'b0, 2'b00},
		'{KIND_START,     32'd0,          16'hFFFF,   1'b1, 2'b11},
		'{KIND_START_LAG, 32'd0,          16'd0,      1'b1, 2'b01},
		'{KIND_TICK,      32'd100,        16'd0,      1'b0, 2'b00},
		'{KIND_STOP,      32'd100,        16'd0,      1'b1, 2'b00}
	};

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                     in_valid  = 1'b0;
	logic                     in_stall;
	kind_t                    req_kind  = KIND_TICK;
	logic [31:0]              req_time  = '0;
	logic [15:0]              req_lag   = '0;

	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic                     led_on;
	logic                     is_running;

	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data  = '0;

	// When this is set, neither side idles. That gives one long stretch at full rate.
	logic calm = 1'b0;

	// These mirror the block's configuration registers, starting from their reset values.
	logic [1:0]  mode_reg   = RST_STROBE_MODE;
	logic [10:0] flash_on   = RST_FLASH_ON_MS;
	logic [15:0] flash_off  = RST_FLASH_OFF_MS;
	logic [15:0] steady_on  = RST_STEADY_ON_MS;
	logic [15:0] steady_off = RST_STEADY_OFF_MS;

	// This mirrors the pattern state of the block.
	logic        strobe_running  = 1'b0;
	logic        strobe_lit_half = 1'b0;
	logic [2:0]  strobe_pulse    = '0;
	logic [31:0] strobe_deadline = '0;
	logic        strobe_led      = 1'b0;

	// The stimulus keeps its own millisecond time. Well-formed ticks advance it, mostly
	// straight onto the predicted deadline, so that the pattern moves through all its states.
	logic [31:0] timebase_ms = '0;

	result_t pending_results[$];
	int      mismatches = 0;
	int      quiet_cycles = 0;

	strobe_flash_pattern_generator i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (req_kind),
		.time_now   (req_time),
		.lag_delay  (req_lag),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.led_on     (led_on),
		.is_running (is_running),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #1 clk = ~clk;

	// Mode 0 lights pulses 0 to 2. The other flash mode lights pulses 0, 1 and 3.
	function automatic logic pulse_lit(logic [1:0] m, logic [2:0] p);
		if (m == MODE_TRIPLE) begin
			return p < 3'd3;
		end
		return (p < 3'd2) || (p == 3'd3);
	endfunction

	// Apply one command to the mirrored state, then return the LED and running flags.
	function automatic result_t next_led_state(kind_t k, logic [31:0] now, logic [15:0] lag);
		result_t     r;
		logic [31:0] long_gap;
		long_gap = (flash_on > LONG_PERIOD_MS) ? 32'd0 : 32'(LONG_PERIOD_MS - flash_on);
		case (k)
			KIND_START: begin
				strobe_deadline = now + 32'(flash_on);
				strobe_running  = 1'b1;
				strobe_lit_half = 1'b1;
				strobe_pulse    = '0;
				strobe_led      = 1'b1;
			end
			KIND_START_LAG: begin
				strobe_deadline = now + 32'(flash_on) + 32'(lag);
				strobe_running  = 1'b1;
				strobe_lit_half = 1'b0;
				strobe_pulse    = '0;
				strobe_led      = 1'b0;
			end
			KIND_STOP: begin
				// Phase, pulse and deadline are kept, so a later tick has no effect until
				// the next start.
				if (strobe_running) begin
					strobe_running = 1'b0;
					strobe_led     = 1'b0;
				end
			end
			default: begin
				if (strobe_running && strobe_deadline <= now) begin
					strobe_lit_half = !strobe_lit_half;
					if (mode_reg >= MODE_STEADY) begin
						strobe_led      = strobe_lit_half;
						strobe_deadline = strobe_deadline +
							32'(strobe_lit_half ? steady_on : steady_off);
					end else if (!strobe_lit_half) begin
						// The end of a pulse. The two-plus-one pattern holds a long gap after
						// each pulse that it skips, and the pulse counter then moves on.
						strobe_led = 1'b0;
						if (mode_reg == MODE_TWO_ONE && !pulse_lit(MODE_TWO_ONE, strobe_pulse)) begin
							strobe_deadline = strobe_deadline + long_gap;
						end else begin
							strobe_deadline = strobe_deadline + 32'(flash_off);
						end
						strobe_pulse = (strobe_pulse == PULSE_COUNT - 3'd1) ? 3'd0
							: strobe_pulse + 3'd1;
					end else begin
						strobe_led      = pulse_lit(mode_reg, strobe_pulse);
						strobe_deadline = strobe_deadline + 32'(flash_on);
					end
				end
			end
		endcase
		r.led_on     = strobe_led;
		r.is_running = strobe_running;
		return r;
	endfunction

	// Offer one request, with random idle cycles before it, and hold it until the block
	// accepts it. The expected result is recorded at the edge that accepts the request.
	task automatic push_request(kind_t k, logic [31:0] t, logic [15:0] lag,
			logic typed = 1'b0, result_t want = '0);
		result_t predicted;
		while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_kind <= k;
		req_time <= t;
		req_lag  <= lag;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		predicted = next_led_state(k, t, lag);
		pending_results.push_back(typed ? want : predicted);
	endtask

	// Hold the sender back until every result that is owed has arrived. Each request
	// yields exactly one result, so an empty queue means that the block is idle.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		case (idx)
			CFG_STROBE_MODE:   mode_reg   = data[1:0];
			CFG_FLASH_ON_MS:   flash_on   = data[10:0];
			CFG_FLASH_OFF_MS:  flash_off  = data;
			CFG_STEADY_ON_MS:  steady_on  = data;
			CFG_STEADY_OFF_MS: steady_off = data;
			default: ;
		endcase
	endtask

	task automatic set_config(logic [1:0] m, logic [15:0] on_ms, logic [15:0] off_ms,
			logic [15:0] s_on_ms, logic [15:0] s_off_ms);
		write_reg(CFG_STROBE_MODE, 16'(m));
		write_reg(CFG_FLASH_ON_MS, on_ms);
		write_reg(CFG_FLASH_OFF_MS, off_ms);
		write_reg(CFG_STEADY_ON_MS, s_on_ms);
		write_reg(CFG_STEADY_OFF_MS, s_off_ms);
		cfg_valid <= 1'b0;
	endtask

	// Most requests are ticks that follow the pattern: they land on the deadline, one
	// millisecond short of it, or a little further on. Starts and stops come now and then.
	// A small share of the requests is noise, with any command, any time and any lag.
	task automatic random_request();
		int          roll;
		int          pick;
		kind_t       k;
		logic [31:0] t;
		logic [15:0] lag;
		roll = $urandom_range(99);
		lag  = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(200));
		if (roll < 6) begin
			k = kind_t'($urandom_range(3));
			t = $urandom;
		end else if (roll < 10) begin
			k = $urandom_range(1) ? KIND_START : KIND_START_LAG;
			t = timebase_ms;
		end else if (roll < 12) begin
			k = KIND_STOP;
			t = timebase_ms;
		end else begin
			k    = KIND_TICK;
			pick = $urandom_range(99);
			if (pick < 50) begin
				timebase_ms = strobe_deadline;
			end else if (pick < 60) begin
				timebase_ms = strobe_deadline - 32'd1;
			end else if (pick >= 65) begin
				timebase_ms = timebase_ms + 32'($urandom_range(300));
			end
			t = timebase_ms;
		end
		push_request(k, t, lag);
	endtask

	task automatic run_phase(int count);
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(99) == 0) begin
				drain_results();
			end
			random_request();
		end
	endtask

	// The receiver stalls at random, except during the calm stretch.
	always @(posedge clk) begin
		out_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
	end

	// Compare each accepted result with the oldest outstanding expectation.
	always @(posedge clk) begin : check_results
		result_t got;
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			got.led_on     = led_on;
			got.is_running = is_running;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, got led_on %0b is_running %0b",
					$time, got.led_on, got.is_running);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (got.led_on !== want.led_on) begin
					$display("%0t: led_on expected %0b got %0b", $time, want.led_on, got.led_on);
					mismatches++;
				end
				if (got.is_running !== want.is_running) begin
					$display("%0t: is_running expected %0b got %0b", $time,
						want.is_running, got.is_running);
					mismatches++;
				end
			end
		end
	end

	// End the run if no channel completes a handshake for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("strobe_flash_pattern_generator: mismatch");
			$finish;
		end else begin
			quiet_cycles++;
		end
	end

	initial begin : stimulus
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		foreach (DIRECTED[r]) begin
			push_request(DIRECTED[r].cmd, DIRECTED[r].now, DIRECTED[r].lag,
				DIRECTED[r].typed, DIRECTED[r].want);
		end

		// Triple flash with every duration at one millisecond.
		drain_results();
		set_config(MODE_TRIPLE, 16'd1, 16'd1, 16'd1, 16'd1);
		timebase_ms = $urandom;
		run_phase(PHASE_REQUESTS);

		// Two-plus-one flash with the default timing. The write to the unused index that
		// comes first must not change anything.
		drain_results();
		write_reg(CFG_UNUSED_IDX, 16'hFFFF);
		set_config(MODE_TWO_ONE, 16'd100, 16'd900, 16'd100, 16'd1900);
		run_phase(PHASE_REQUESTS);

		// Two-plus-one flash with every duration register at its maximum. The 11-bit on time
		// then exceeds the long period, so the long gap saturates at zero. Time starts close to its wrap.
		drain_results();
		set_config(MODE_TWO_ONE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		timebase_ms = 32'hFFFF_0000;
		run_phase(PHASE_REQUESTS);

		// Steady blink, with a very long lit time and a one millisecond dark time. Neither
		// side idles during this phase.
		drain_results();
		calm <= 1'b1;
		set_config(MODE_STEADY, 16'd100, 16'd900, 16'hFFFF, 16'd1);
		run_phase(PHASE_REQUESTS);
		calm <= 1'b0;

		// Mode three with every duration zero. The deadline then stays put, and each tick
		// that is due toggles the LED again.
		drain_results();
		set_config(MODE_STEADY_ALT, 16'd0, 16'd0, 16'd0, 16'd0);
		run_phase(PHASE_REQUESTS);

		// Random timing in each of the three modes.
		drain_results();
		set_config(MODE_TRIPLE, 16'($urandom_range(1, 1999)), 16'($urandom_range(1, 3000)),
			16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
		timebase_ms = $urandom;
		run_phase(PHASE_REQUESTS);

		drain_results();
		set_config(MODE_TWO_ONE, 16'($urandom_range(1, 1999)), 16'($urandom_range(1, 65535)),
			16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
		run_phase(PHASE_REQUESTS);

		drain_results();
		set_config(MODE_STEADY, 16'($urandom_range(1, 1999)), 16'($urandom_range(1, 65535)),
			16'($urandom_range(1, 3000)), 16'($urandom_range(1, 3000)));
		timebase_ms = $urandom;
		run_phase(PHASE_REQUESTS);

		// Wait for the last results, then keep the clock running in case a stray result
		// still follows.
		drain_results();
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("strobe_flash_pattern_generator: match");
		end else begin
			$display("strobe_flash_pattern_generator: mismatch");
		end
		$finish;
	end

endmodule
